>>> hdl/hsv_threshold_centroid_macros.svh
// Assertion macros shared by the HSV threshold centroid block.
`ifndef HSV_THRESHOLD_CENTROID_MACROS_SVH
`define HSV_THRESHOLD_CENTROID_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define HSVTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define HSVTC_ASSERT_NEVER(lbl, cond, msg) \
  `HSVTC_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/hsvtc_pkg.sv
// Package with the types, widths and register codes of the HSV threshold centroid block.
package hsvtc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int FRAC_BITS  = 8;

  localparam int CH_W   = 8;
  localparam int LW_W   = 11;
  localparam int SUM_W  = 30;
  localparam int CNT_W  = 21;
  localparam int CENT_W = 18;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  // Width used to compare the next column against the line width.
  localparam int CMP_W = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

  localparam int DVD_W  = SUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  localparam int IDX_W       = 3;
  localparam int CFG_W       = LW_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_USED_W  = 2 * CENT_W + CNT_W;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd640;

  typedef enum logic [IDX_W-1:0] {
    CFG_HUE_LOW    = 3'd0,
    CFG_SAT_LOW    = 3'd1,
    CFG_VAL_LOW    = 3'd2,
    CFG_HUE_HIGH   = 3'd3,
    CFG_SAT_HIGH   = 3'd4,
    CFG_VAL_HIGH   = 3'd5,
    CFG_LINE_WIDTH = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] hue_low;
    logic [CH_W-1:0] sat_low;
    logic [CH_W-1:0] val_low;
    logic [CH_W-1:0] hue_high;
    logic [CH_W-1:0] sat_high;
    logic [CH_W-1:0] val_high;
    logic [LW_W-1:0] line_width;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> hdl/hsvtc_front.sv
// Pixel front end: threshold test, raster position and per-frame accumulation.
module hsvtc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hsvtc_pkg::cfg_t             cfg_i,
  input  logic                        pix_valid_i,
  output logic                        pix_ready_o,
  input  logic [hsvtc_pkg::CH_W-1:0]  pix_hue_i,
  input  logic [hsvtc_pkg::CH_W-1:0]  pix_sat_i,
  input  logic [hsvtc_pkg::CH_W-1:0]  pix_bri_i,
  input  logic                        pix_eof_i,
  input  hsvtc_pkg::fifo_stat_t       q_stat_i,
  output logic                        push_o,
  output hsvtc_pkg::frame_rec_t       rec_o
);

  localparam int CMP_W = hsvtc_pkg::CMP_W;
  localparam int COL_W = hsvtc_pkg::COL_W;
  localparam int ROW_W = hsvtc_pkg::ROW_W;
  localparam int SUM_W = hsvtc_pkg::SUM_W;
  localparam int CNT_W = hsvtc_pkg::CNT_W;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [SUM_W-1:0] sx_q, sx_d, sy_q, sy_d, sx_acc, sy_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_acc;

  logic             accept, pass;
  logic [CMP_W-1:0] lw_ext, width, col_inc;
  logic [ROW_W:0]   row_inc;
  logic [SUM_W:0]   sx_sum, sy_sum;
  logic [CNT_W:0]   cnt_sum;

  // The whole stream waits while the frame queue is full.
  assign pix_ready_o = !q_stat_i.full;
  assign accept      = pix_valid_i && pix_ready_o;

  assign pass = (pix_hue_i >= cfg_i.hue_low) && (pix_hue_i <= cfg_i.hue_high) &&
                (pix_sat_i >= cfg_i.sat_low) && (pix_sat_i <= cfg_i.sat_high) &&
                (pix_bri_i >= cfg_i.val_low) && (pix_bri_i <= cfg_i.val_high);

  // A line width of zero acts as one, a width beyond the maximum as the maximum.
  assign lw_ext = CMP_W'(cfg_i.line_width);
  always_comb begin
    if (lw_ext == '0) begin
      width = CMP_W'(1);
    end else if (lw_ext > CMP_W'(hsvtc_pkg::MAX_WIDTH)) begin
      width = CMP_W'(hsvtc_pkg::MAX_WIDTH);
    end else begin
      width = lw_ext;
    end
  end

  assign col_inc = CMP_W'(col_q) + CMP_W'(1);
  assign row_inc = (ROW_W + 1)'(row_q) + (ROW_W + 1)'(1);

  // Saturating accumulation of the passing pixels.
  assign sx_sum  = (SUM_W + 1)'(sx_q) + (SUM_W + 1)'(col_q);
  assign sy_sum  = (SUM_W + 1)'(sy_q) + (SUM_W + 1)'(row_q);
  assign cnt_sum = (CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(1);

  always_comb begin
    sx_acc  = sx_q;
    sy_acc  = sy_q;
    cnt_acc = cnt_q;
    if (pass) begin
      sx_acc  = sx_sum[SUM_W] ? '1 : sx_sum[SUM_W-1:0];
      sy_acc  = sy_sum[SUM_W] ? '1 : sy_sum[SUM_W-1:0];
      cnt_acc = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (pix_eof_i) begin
        col_d = '0;
        row_d = '0;
        sx_d  = '0;
        sy_d  = '0;
        cnt_d = '0;
      end else begin
        sx_d  = sx_acc;
        sy_d  = sy_acc;
        cnt_d = cnt_acc;
        if (col_inc >= width) begin
          col_d = '0;
          row_d = (row_inc >= (ROW_W + 1)'(hsvtc_pkg::MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
        end else begin
          col_d = col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      cnt_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      cnt_q <= cnt_d;
    end
  end

  // The last pixel of a frame is counted before the totals go to the queue.
  assign push_o      = accept && pix_eof_i;
  assign rec_o.sum_x = sx_acc;
  assign rec_o.sum_y = sy_acc;
  assign rec_o.count = cnt_acc;

endmodule

>>> hdl/hsvtc_fifo.sv
// Short queue of frame totals between the pixel front end and the divider.
module hsvtc_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  hsvtc_pkg::frame_rec_t   rec_i,
  input  logic                    pop_i,
  output hsvtc_pkg::frame_rec_t   rec_o,
  output hsvtc_pkg::fifo_stat_t   stat_o
);

  localparam int DEPTH  = hsvtc_pkg::FIFO_DEPTH;
  localparam int PTR_W  = hsvtc_pkg::PTR_W;
  localparam int FILL_W = hsvtc_pkg::FILL_W;

  hsvtc_pkg::frame_rec_t mem_q [DEPTH];

  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  assign rec_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (fill_q == FILL_W'(DEPTH));
  assign stat_o.empty = (fill_q == '0);

endmodule

>>> hdl/hsvtc_div.sv
// Back end: restoring division of both coordinate sums and the result register.
module hsvtc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hsvtc_pkg::frame_rec_t         rec_i,
  input  hsvtc_pkg::fifo_stat_t         q_stat_i,
  output logic                          pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [hsvtc_pkg::CENT_W-1:0]  res_cx_o,
  output logic [hsvtc_pkg::CENT_W-1:0]  res_cy_o,
  output logic [hsvtc_pkg::CNT_W-1:0]   res_area_o,
  output logic                          res_found_o
);

  localparam int DVD_W  = hsvtc_pkg::DVD_W;
  localparam int CNT_W  = hsvtc_pkg::CNT_W;
  localparam int CENT_W = hsvtc_pkg::CENT_W;
  localparam int STEP_W = hsvtc_pkg::STEP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } div_state_e;

  div_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  dvx_q, dvx_d, dvy_q, dvy_d;
  logic [CNT_W-1:0]  remx_q, remx_d, remy_q, remy_d, div_q, div_d;
  logic              out_valid_q, out_valid_d;
  logic [CENT_W-1:0] cx_q, cy_q;
  logic [CNT_W-1:0]  area_q;
  logic              found_q;

  logic [CNT_W:0]    trial_x, trial_y, div_ext;
  logic              ge_x, ge_y, load_out, found;

  // Quotients that do not fit the centroid field clip to its maximum.
  function automatic logic [CENT_W-1:0] clip(input logic [DVD_W-1:0] q);
    clip = (|q[DVD_W-1:CENT_W]) ? '1 : q[CENT_W-1:0];
  endfunction

  // One quotient bit per cycle for each coordinate; both share the divisor.
  assign div_ext = {1'b0, div_q};
  assign trial_x = {remx_q, dvx_q[DVD_W-1]};
  assign trial_y = {remy_q, dvy_q[DVD_W-1]};
  assign ge_x    = trial_x >= div_ext;
  assign ge_y    = trial_y >= div_ext;

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || res_ready_i);
  assign found    = (div_q != '0);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    dvx_d       = dvx_q;
    dvy_d       = dvy_q;
    remx_d      = remx_q;
    remy_d      = remy_q;
    div_d       = div_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q;
    if (res_valid_o && res_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          dvx_d   = {rec_i.sum_x, {hsvtc_pkg::FRAC_BITS{1'b0}}};
          dvy_d   = {rec_i.sum_y, {hsvtc_pkg::FRAC_BITS{1'b0}}};
          remx_d  = '0;
          remy_d  = '0;
          div_d   = rec_i.count;
          step_d  = STEP_W'(DVD_W);
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        remx_d = ge_x ? CNT_W'(trial_x - div_ext) : trial_x[CNT_W-1:0];
        remy_d = ge_y ? CNT_W'(trial_y - div_ext) : trial_y[CNT_W-1:0];
        dvx_d  = {dvx_q[DVD_W-2:0], ge_x};
        dvy_d  = {dvy_q[DVD_W-2:0], ge_y};
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvx_q  <= dvx_d;
    dvy_q  <= dvy_d;
    remx_q <= remx_d;
    remy_q <= remy_d;
    div_q  <= div_d;
  end

  // An empty frame gives zero centroids with the found flag cleared.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      cx_q    <= found ? clip(dvx_q) : '0;
      cy_q    <= found ? clip(dvy_q) : '0;
      area_q  <= div_q;
      found_q <= found;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_cx_o    = cx_q;
  assign res_cy_o    = cy_q;
  assign res_area_o  = area_q;
  assign res_found_o = found_q;

endmodule

>>> hdl/hsv_threshold_centroid.sv
// Top level of the HSV threshold centroid block: registers, front end, queue and divider.
//
// Pixels come in on the slave stream, one beat per pixel in row order, with
// tlast on the last pixel of a frame. A pixel passes when hue, saturation and
// value all lie inside their inclusive bounds; the block sums the column and
// row of every passing pixel and counts them. The pixel front end takes one
// beat per clock cycle while the frame queue is not full.
// At the end of a frame the totals go into a two-entry queue. A restoring
// divider, whose divisor both sums share, works out both centroids side by
// side, one quotient bit per cycle, then loads the output register.
// Results leave on the master stream, one beat per frame; tuser carries the
// found flag, and an empty frame gives zero centroids with found low.
// A result that waits for the receiver sits in the output register while the
// divider already works on the next frame; tready on the slave side drops
// whenever the queue is full, so frames that come back to back faster than
// the divider finishes them are throttled by the divider.
// Reset clears the position counters, the sums, the queue and the output,
// and sets the bounds to their full range and the line width to 640.
// The user writes registers through the plain write port only while the block is idle; the block does not enforce it.
`include "hsv_threshold_centroid_macros.svh"

module hsv_threshold_centroid (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [hsvtc_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [hsvtc_pkg::CFG_W-1:0]          cfg_data_i,
  // Pixel stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata fields from bit 0: hue[7:0], saturation[15:8], brightness[23:16].
  input  logic [hsvtc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata fields from bit 0: centroid_x[17:0], centroid_y[35:18], area[56:36],
  // zero fill above.
  output logic [hsvtc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser fields from bit 0: found.
  output logic                                 m_axis_tuser
);

  localparam int CH_W   = hsvtc_pkg::CH_W;
  localparam int CENT_W = hsvtc_pkg::CENT_W;
  localparam int CNT_W  = hsvtc_pkg::CNT_W;

  hsvtc_pkg::cfg_t       cfg_q, cfg_d;
  hsvtc_pkg::frame_rec_t push_rec, pop_rec;
  hsvtc_pkg::fifo_stat_t fifo_stat;
  logic                  fifo_push, fifo_pop;
  logic [CENT_W-1:0]     res_cx, res_cy;
  logic [CNT_W-1:0]      res_area;
  logic                  res_found;

  // Register writes; the eight bit bounds take the low byte of the data and
  // an index beyond the list is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (hsvtc_pkg::cfg_idx_e'(cfg_idx_i))
        hsvtc_pkg::CFG_HUE_LOW:    cfg_d.hue_low    = cfg_data_i[CH_W-1:0];
        hsvtc_pkg::CFG_SAT_LOW:    cfg_d.sat_low    = cfg_data_i[CH_W-1:0];
        hsvtc_pkg::CFG_VAL_LOW:    cfg_d.val_low    = cfg_data_i[CH_W-1:0];
        hsvtc_pkg::CFG_HUE_HIGH:   cfg_d.hue_high   = cfg_data_i[CH_W-1:0];
        hsvtc_pkg::CFG_SAT_HIGH:   cfg_d.sat_high   = cfg_data_i[CH_W-1:0];
        hsvtc_pkg::CFG_VAL_HIGH:   cfg_d.val_high   = cfg_data_i[CH_W-1:0];
        hsvtc_pkg::CFG_LINE_WIDTH: cfg_d.line_width = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low    <= '0;
      cfg_q.sat_low    <= '0;
      cfg_q.val_low    <= '0;
      cfg_q.hue_high   <= '1;
      cfg_q.sat_high   <= '1;
      cfg_q.val_high   <= '1;
      cfg_q.line_width <= hsvtc_pkg::LINE_WIDTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hsvtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_hue_i   (s_axis_tdata[7:0]),
    .pix_sat_i   (s_axis_tdata[15:8]),
    .pix_bri_i   (s_axis_tdata[23:16]),
    .pix_eof_i   (s_axis_tlast),
    .q_stat_i    (fifo_stat),
    .push_o      (fifo_push),
    .rec_o       (push_rec)
  );

  hsvtc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .rec_i  (push_rec),
    .pop_i  (fifo_pop),
    .rec_o  (pop_rec),
    .stat_o (fifo_stat)
  );

  hsvtc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (pop_rec),
    .q_stat_i    (fifo_stat),
    .pop_o       (fifo_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_cx_o    (res_cx),
    .res_cy_o    (res_cy),
    .res_area_o  (res_area),
    .res_found_o (res_found)
  );

  assign m_axis_tdata = {{(hsvtc_pkg::OUT_TDATA_W - hsvtc_pkg::OUT_USED_W){1'b0}},
                         res_area, res_cy, res_cx};
  assign m_axis_tuser = res_found;

  // The front end must never write a full queue, nor the divider read an empty one.
  `HSVTC_ASSERT_NEVER(a_no_push_when_full, fifo_push && fifo_stat.full, "frame queue overrun")
  `HSVTC_ASSERT_NEVER(a_no_pop_when_empty, fifo_pop && fifo_stat.empty, "frame queue underrun")
  // A result without a hit carries all-zero fields; a hit implies a nonzero area.
  `HSVTC_ASSERT(a_empty_frame_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "empty frame with nonzero fields")
  `HSVTC_ASSERT(a_found_has_area, m_axis_tvalid && m_axis_tuser |-> res_area != '0, "found set with zero area")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the HSV threshold centroid block: stream driver, monitor, frame predictor.
`timescale 1ns / 100ps

module tb_top;
  import hsvtc_pkg::*;

  // An index past the register list; writes to it must change nothing.
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  // Cycles the receiver holds off in the back-pressure phase.
  localparam int HOLD_CYCLES = 600;
  // Quiet time after the last result.
  localparam int DRAIN_CYCLES = 60;

  // One pixel beat as the sender sees it.
  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] sat;
    logic [CH_W-1:0] val;
    logic            eof;
  } pixel_t;

  // One frame report: centroids, pixel count and the found flag.
  typedef struct packed {
    logic [CENT_W-1:0] cx;
    logic [CENT_W-1:0] cy;
    logic [CNT_W-1:0]  area;
    logic              found;
  } blob_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [IDX_W-1:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  hsv_threshold_centroid DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Pixels waiting to be driven, and frame reports waiting to be seen.
  pixel_t pixel_q[$];
  blob_t  blob_q[$];
  int     mismatch_cnt = 0;

  // Idle and stall rates in percent, changed only between phases.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  // The main process toggles hold_req; the receiver then holds off on its own.
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  // Predictor state: thresholds, line width and the running frame sums.
  cfg_t             thr = '{hue_low: 8'd0, sat_low: 8'd0, val_low: 8'd0,
                            hue_high: 8'd255, sat_high: 8'd255, val_high: 8'd255,
                            line_width: LINE_WIDTH_RST};
  logic [SUM_W-1:0] col_sum = '0;
  logic [SUM_W-1:0] row_sum = '0;
  logic [CNT_W-1:0] hit_cnt = '0;
  logic [COL_W-1:0] col_pos = '0;
  logic [ROW_W-1:0] row_pos = '0;

  // Sums saturate at all ones rather than wrapping.
  function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] acc, longint unsigned v);
    longint unsigned s;
    s = longint'(acc) + v;
    return (s > (64'd1 << SUM_W) - 1) ? '1 : s[SUM_W-1:0];
  endfunction

  // Mean in fixed point with FRAC_BITS fraction bits, truncated and clipped.
  function automatic logic [CENT_W-1:0] mean_fix(logic [SUM_W-1:0] sum, logic [CNT_W-1:0] n);
    longint unsigned q;
    if (n == 0) return '0;
    q = (longint'(sum) << FRAC_BITS) / longint'(n);
    return (q > (64'd1 << CENT_W) - 1) ? '1 : q[CENT_W-1:0];
  endfunction

  // Advances the frame sums by one accepted pixel and, on the last pixel of
  // a frame, queues the report the block has to produce.
  function automatic void track_pixel(pixel_t px);
    int    wid;
    logic  hit;
    blob_t rep;
    wid = int'(thr.line_width);
    if (wid == 0) wid = 1;
    if (wid > MAX_WIDTH) wid = MAX_WIDTH;
    hit = px.hue >= thr.hue_low && px.hue <= thr.hue_high &&
          px.sat >= thr.sat_low && px.sat <= thr.sat_high &&
          px.val >= thr.val_low && px.val <= thr.val_high;
    if (hit) begin
      if (hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
      col_sum = add_sat(col_sum, col_pos);
      row_sum = add_sat(row_sum, row_pos);
    end
    if (px.eof) begin
      rep.cx    = mean_fix(col_sum, hit_cnt);
      rep.cy    = mean_fix(row_sum, hit_cnt);
      rep.area  = hit_cnt;
      rep.found = (hit_cnt != 0);
      blob_q.push_back(rep);
      col_sum = '0;
      row_sum = '0;
      hit_cnt = '0;
      col_pos = '0;
      row_pos = '0;
    end else if (int'(col_pos) + 1 >= wid) begin
      col_pos = '0;
      row_pos = (int'(row_pos) + 1 >= MAX_HEIGHT) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic void cmp_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Compares a result beat with the oldest pending frame report.
  function automatic void check_report();
    blob_t want;
    if (blob_q.size() == 0) begin
      $display("%0t: result beat with no frame pending, expected none, got tdata %h found %b",
               $time, m_axis_tdata, m_axis_tuser);
      mismatch_cnt++;
    end else begin
      want = blob_q.pop_front();
      cmp_field("centroid_x", want.cx, m_axis_tdata[CENT_W-1:0]);
      cmp_field("centroid_y", want.cy, m_axis_tdata[2*CENT_W-1:CENT_W]);
      cmp_field("area", want.area, m_axis_tdata[OUT_USED_W-1:2*CENT_W]);
      cmp_field("found", want.found, m_axis_tuser);
      cmp_field("tdata fill", 0, m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W]);
    end
  endfunction

  // Pixel driver. A new beat is offered only when the slot is free or the
  // current beat is being taken, so tvalid never drops under a pending beat.
  always @(posedge clk_i) begin
    pixel_t px;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        px = pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.val, px.sat, px.hue};
        s_axis_tlast  <= px.eof;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver. A toggle of hold_req starts a long hold-off that this
  // process counts down; otherwise tready follows the current stall rate.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor. Both handshakes are sampled at the same edge; the input side is
  // handled first so the predictor always leads the result side.
  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        px.hue = s_axis_tdata[CH_W-1:0];
        px.sat = s_axis_tdata[2*CH_W-1:CH_W];
        px.val = s_axis_tdata[3*CH_W-1:2*CH_W];
        px.eof = s_axis_tlast;
        track_pixel(px);
      end
      if (m_axis_tvalid && m_axis_tready) check_report();
    end
  end

  // Writes one register and mirrors it in the predictor. The 8-bit bounds
  // keep only the low byte of the write data.
  task automatic write_reg(logic [IDX_W-1:0] idx, int data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(data);
    case (idx)
      CFG_HUE_LOW:    thr.hue_low    = data[CH_W-1:0];
      CFG_SAT_LOW:    thr.sat_low    = data[CH_W-1:0];
      CFG_VAL_LOW:    thr.val_low    = data[CH_W-1:0];
      CFG_HUE_HIGH:   thr.hue_high   = data[CH_W-1:0];
      CFG_SAT_HIGH:   thr.sat_high   = data[CH_W-1:0];
      CFG_VAL_HIGH:   thr.val_high   = data[CH_W-1:0];
      CFG_LINE_WIDTH: thr.line_width = data[CFG_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_full_range();
    write_reg(CFG_HUE_LOW, 0);
    write_reg(CFG_SAT_LOW, 0);
    write_reg(CFG_VAL_LOW, 0);
    write_reg(CFG_HUE_HIGH, 255);
    write_reg(CFG_SAT_HIGH, 255);
    write_reg(CFG_VAL_HIGH, 255);
  endtask

  // Random bounds for one channel: mostly ordered, sometimes the full range,
  // sometimes inverted. Junk goes into the unused upper data bits.
  task automatic random_bounds(logic [IDX_W-1:0] lo_idx, logic [IDX_W-1:0] hi_idx);
    logic [CH_W-1:0] a, b, t;
    logic [2:0]      junk_a, junk_b;
    int              r;
    a = CH_W'($urandom_range(255));
    b = CH_W'($urandom_range(255));
    junk_a = 3'($urandom_range(7));
    junk_b = 3'($urandom_range(7));
    r = $urandom_range(9);
    if (r == 0) begin
      a = 8'd0;
      b = 8'd255;
    end else if (r > 1 && a > b) begin
      t = a;
      a = b;
      b = t;
    end
    write_reg(lo_idx, int'({junk_a, a}));
    write_reg(hi_idx, int'({junk_b, b}));
  endtask

  // Short lines are favored so that the row counter moves in short frames;
  // zero and widths past the maximum show up now and then.
  task automatic random_config();
    int r;
    int lw;
    random_bounds(CFG_HUE_LOW, CFG_HUE_HIGH);
    random_bounds(CFG_SAT_LOW, CFG_SAT_HIGH);
    random_bounds(CFG_VAL_LOW, CFG_VAL_HIGH);
    r = $urandom_range(9);
    if (r < 6) lw = $urandom_range(16, 1);
    else if (r < 9) lw = $urandom_range(700, 17);
    else if ($urandom_range(1) == 0) lw = 0;
    else lw = $urandom_range(2047, MAX_WIDTH + 1);
    write_reg(CFG_LINE_WIDTH, lw);
  endtask

  // Picks a channel value: often right at or just past a bound, mostly
  // inside the window, sometimes anywhere.
  function automatic logic [CH_W-1:0] pick_chan(logic [CH_W-1:0] lo, logic [CH_W-1:0] hi);
    int r;
    r = $urandom_range(11);
    case (r)
      0: return lo;
      1: return hi;
      2: return lo - 1'b1;
      3: return hi + 1'b1;
      10, 11: return CH_W'($urandom_range(255));
      default: return (lo <= hi) ? CH_W'($urandom_range(hi, lo)) : CH_W'($urandom_range(255));
    endcase
  endfunction

  task automatic add_px(int h, int s, int v, bit eof);
    pixel_t px;
    px.hue = CH_W'(h);
    px.sat = CH_W'(s);
    px.val = CH_W'(v);
    px.eof = eof;
    pixel_q.push_back(px);
  endtask

  // Queues whole frames of random length until n_pix pixels are queued; the
  // last pixel always closes a frame.
  task automatic queue_frames(int n_pix, int max_len);
    int left, len;
    left = n_pix;
    while (left > 0) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(4 * max_len, 1) : $urandom_range(max_len, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        add_px(pick_chan(thr.hue_low, thr.hue_high), pick_chan(thr.sat_low, thr.sat_high),
               pick_chan(thr.val_low, thr.val_high), i == len - 1);
      end
      left -= len;
    end
  endtask

  // One frame of fully random pixels on the current configuration.
  task automatic queue_long_frame(int len);
    for (int i = 0; i < len; i++) begin
      add_px($urandom_range(255), $urandom_range(255), $urandom_range(255), i == len - 1);
    end
  endtask

  // Waits until every pixel went in and every report came out, then leaves
  // the divider time to settle before anything is reconfigured.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || blob_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_rates(int idle_pct, int stall_pct);
    @(posedge clk_i);
    src_idle_pct   <= idle_pct;
    sink_stall_pct <= stall_pct;
  endtask

  // A random phase: fresh configuration, then frames at the given rates.
  task automatic random_phase(int idle_pct, int stall_pct, int n_pix);
    random_config();
    set_rates(idle_pct, stall_pct);
    @(negedge clk_i);
    queue_frames(n_pix, 12);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: full-range bounds and 640-pixel lines. A lone pixel
    // frame, then three pixels on one row averaging to column one.
    @(negedge clk_i);
    add_px(0, 0, 0, 1'b1);
    add_px(255, 255, 255, 1'b0);
    add_px(8'hAA, 8'h55, 8'hFF, 1'b0);
    add_px(8'h55, 8'hAA, 8'h00, 1'b1);
    wait_drained();

    // Narrow windows on three-pixel lines; each bound is hit exactly and
    // missed by one on either side. The spare index must be ignored.
    write_reg(CFG_HUE_LOW, 10);
    write_reg(CFG_SAT_LOW, 30);
    write_reg(CFG_VAL_LOW, 50);
    write_reg(CFG_HUE_HIGH, 20);
    write_reg(CFG_SAT_HIGH, 40);
    write_reg(CFG_VAL_HIGH, 60);
    write_reg(CFG_LINE_WIDTH, 3);
    write_reg(CFG_IDX_SPARE, 'h7FF);
    @(negedge clk_i);
    add_px(10, 30, 50, 1'b0);
    add_px(20, 40, 60, 1'b0);
    add_px(9, 35, 55, 1'b0);
    add_px(21, 35, 55, 1'b0);
    add_px(15, 29, 55, 1'b0);
    add_px(15, 41, 55, 1'b0);
    add_px(15, 35, 49, 1'b0);
    add_px(15, 35, 61, 1'b0);
    add_px(15, 35, 55, 1'b1);
    // Empty frame: nothing passes, so zero centroids and found low.
    add_px(0, 0, 0, 1'b1);
    wait_drained();

    // Inverted hue bounds let nothing through, not even the bound values.
    // Line width zero behaves as one pixel per line.
    write_reg(CFG_HUE_LOW, 200);
    write_reg(CFG_HUE_HIGH, 100);
    write_reg(CFG_LINE_WIDTH, 0);
    @(negedge clk_i);
    add_px(150, 35, 55, 1'b0);
    add_px(200, 35, 55, 1'b0);
    add_px(100, 35, 55, 1'b1);
    wait_drained();
    write_reg(CFG_HUE_LOW, 0);
    write_reg(CFG_HUE_HIGH, 255);
    @(negedge clk_i);
    add_px(15, 35, 55, 1'b0);
    add_px(15, 35, 55, 1'b0);
    add_px(15, 35, 55, 1'b1);
    wait_drained();

    // Random phases: steady flow first, then an idle sender, a stalling
    // receiver, and both at once.
    random_phase(0, 0, 95);
    random_phase(74, 0, 95);
    random_phase(0, 74, 95);
    random_phase(35, 35, 95);

    // Back pressure: the receiver holds off for a long stretch while short
    // frames keep coming, so the output register and the frame queue fill
    // and the block has to drop tready on the pixel side.
    set_full_range();
    write_reg(CFG_LINE_WIDTH, 2);
    @(posedge clk_i);
    src_idle_pct   <= 0;
    sink_stall_pct <= 0;
    hold_req       <= ~hold_req;
    @(negedge clk_i);
    queue_frames(40, 3);
    wait_drained();

    // One pixel per line moves the row counter on every pixel; then a width
    // above the maximum, which must act the same as the widest line.
    write_reg(CFG_LINE_WIDTH, 1);
    set_rates(0, 20);
    @(negedge clk_i);
    queue_long_frame(10);
    wait_drained();
    write_reg(CFG_LINE_WIDTH, 'h7FF);
    write_reg(CFG_VAL_LOW, 16);
    @(negedge clk_i);
    queue_long_frame(10);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run of this stimulus.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> hsv_threshold_centroid.f
+incdir+hdl
hdl/hsvtc_pkg.sv
hdl/hsvtc_front.sv
hdl/hsvtc_fifo.sv
hdl/hsvtc_div.sv
hdl/hsv_threshold_centroid.sv
bench/tb_top.sv
